[rtl/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin task scheduler
// Field widths, request codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  // Field widths
  localparam int unsigned ID_W   = 4;   // task id, task count
  localparam int unsigned DATA_W = 32;  // timeout and event mask
  localparam int unsigned REQ_W  = 3;   // request code

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_YIELD  = 3'd1,
    REQ_DELAY  = 3'd2,
    REQ_WAIT   = 3'd3,
    REQ_FEED   = 3'd4,
    REQ_CANCEL = 3'd5
  } req_e;

  // Result of one request
  typedef struct packed {
    logic [ID_W-1:0] running_task;
    logic            none_runnable;
    logic            delay_expired;
    logic            status;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/rrts_if.sv]
// ----------------------------------------------------------------------------
// rrts_if: channel interfaces of the task scheduler
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrts_req_if;
  logic                        valid;
  logic                        ready;
  logic [rrts_pkg::REQ_W-1:0]  req_type;
  logic [rrts_pkg::DATA_W-1:0] amount;
  logic [rrts_pkg::DATA_W-1:0] event_bits;
  logic [rrts_pkg::ID_W-1:0]   target_task;

  modport source (output valid, req_type, amount, event_bits, target_task, input ready);
  modport sink   (input valid, req_type, amount, event_bits, target_task, output ready);
endinterface

interface rrts_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [rrts_pkg::ID_W-1:0] running_task;
  logic                      none_runnable;
  logic                      delay_expired;
  logic                      status;

  modport source (output valid, running_task, none_runnable, delay_expired, status,
                  input ready);
  modport sink   (input valid, running_task, none_runnable, delay_expired, status,
                  output ready);
endinterface

interface rrts_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rrts_pkg::ID_W-1:0] task_count;

  modport source (output valid, task_count, input ready);
  modport sink   (input valid, task_count, output ready);
endinterface

`default_nettype wire

[rtl/round_robin_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top: hardware round-robin task scheduler
// Holds per-task timeouts and event wait masks in two memories and answers
// each request with the running task and status flags.
//
//   channel | dir | handshake     | payload
//   req_i   | in  | valid / ready | req_type, amount, event_bits, target_task
//   rsp_o   | out | valid / ready | running_task, none_runnable, delay_expired, status
//   cfg_i   | in  | valid / ready | task_count (always ready)
//
// Tick and yield visit one task entry per cycle, limited by the single read
// port of each memory. Delay and cancel write their entry at once; wait and
// feed read the mask entry and write it back (read-modify-write).
// One request is in flight at a time; the response register lets the next
// request start while a result waits. Reset clears all entries at once
// through per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler_top #(
  parameter int unsigned MAX_TASKS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rrts_req_if.sink    req_i,
  rrts_rsp_if.source  rsp_o,
  rrts_cfg_if.sink    cfg_i
);

  localparam int unsigned DEPTH = MAX_TASKS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [rrts_pkg::ID_W-1:0]   task_count_q;
  logic [rrts_pkg::ID_W-1:0]   live_n;
  logic                        rsp_valid_q;
  rrts_pkg::rsp_t              rsp_q;
  rrts_pkg::rsp_t              seq_rsp;
  logic                        seq_done;
  logic                        out_free;

  logic                        to_rd_en, to_wr_en, mk_rd_en, mk_wr_en;
  logic [AW-1:0]               to_rd_addr, to_wr_addr, mk_rd_addr, mk_wr_addr;
  logic [rrts_pkg::DATA_W-1:0] to_rd_data, to_wr_data, mk_rd_data, mk_wr_data;

  // Task count register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= '0;
    end else if (cfg_i.valid) begin
      task_count_q <= cfg_i.task_count;
    end
  end

  // Count of live user tasks, capped at the table size
  assign live_n = (int'(task_count_q) > MAX_TASKS) ? rrts_pkg::ID_W'(MAX_TASKS)
                                                   : task_count_q;

  // Response register
  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (seq_done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      rsp_q <= seq_rsp;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.running_task  = rsp_q.running_task;
  assign rsp_o.none_runnable = rsp_q.none_runnable;
  assign rsp_o.delay_expired = rsp_q.delay_expired;
  assign rsp_o.status        = rsp_q.status;

  // Request sequencer
  rrts_seq #(
    .AW (AW)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_type_i    (req_i.req_type),
    .amount_i      (req_i.amount),
    .event_bits_i  (req_i.event_bits),
    .target_task_i (req_i.target_task),
    .n_i           (live_n),
    .out_free_i    (out_free),
    .done_o        (seq_done),
    .rsp_o         (seq_rsp),
    .to_rd_en_o    (to_rd_en),
    .to_rd_addr_o  (to_rd_addr),
    .to_rd_data_i  (to_rd_data),
    .to_wr_en_o    (to_wr_en),
    .to_wr_addr_o  (to_wr_addr),
    .to_wr_data_o  (to_wr_data),
    .mk_rd_en_o    (mk_rd_en),
    .mk_rd_addr_o  (mk_rd_addr),
    .mk_rd_data_i  (mk_rd_data),
    .mk_wr_en_o    (mk_wr_en),
    .mk_wr_addr_o  (mk_wr_addr),
    .mk_wr_data_o  (mk_wr_data)
  );

  // Timeout memory
  rrts_mem #(
    .WIDTH (rrts_pkg::DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_timeout_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (to_rd_en),
    .rd_addr_i (to_rd_addr),
    .rd_data_o (to_rd_data),
    .wr_en_i   (to_wr_en),
    .wr_addr_i (to_wr_addr),
    .wr_data_i (to_wr_data)
  );

  // Wait mask memory
  rrts_mem #(
    .WIDTH (rrts_pkg::DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mask_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mk_rd_en),
    .rd_addr_i (mk_rd_addr),
    .rd_data_o (mk_rd_data),
    .wr_en_i   (mk_wr_en),
    .wr_addr_i (mk_wr_addr),
    .wr_data_i (mk_wr_data)
  );

`ifndef ASSERT_OFF
  // A taken request leaves request ready low in the following cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request ready did not drop after a request was taken");

  // A yield that found nothing cannot also report an expired delay
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.none_runnable && rsp_o.delay_expired))
    else $error("none_runnable and delay_expired both set");

  // Running task always addresses a memory entry
  a_task_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |=> (int'(rsp_o.running_task) <= MAX_TASKS))
    else $error("running task beyond the task table");
`endif

endmodule

`default_nettype wire

[rtl/rrts_mem.sv]
// ----------------------------------------------------------------------------
// rrts_mem: per-task state memory
// One write and one read port, registered read data; entries never written
// since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_mem #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 9,
  parameter int unsigned AW    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output      logic [WIDTH-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvld_q;

  // Storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Written flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

[rtl/rrts_seq.sv]
// ----------------------------------------------------------------------------
// rrts_seq: request sequencer of the task scheduler
// Walks the timeout and mask memories one entry per cycle for tick and
// yield, and does single-entry writes or read-modify-writes for the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_seq #(
  parameter int unsigned AW = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request side
  input  wire logic                        req_valid_i,
  output      logic                        req_ready_o,
  input  wire logic [rrts_pkg::REQ_W-1:0]  req_type_i,
  input  wire logic [rrts_pkg::DATA_W-1:0] amount_i,
  input  wire logic [rrts_pkg::DATA_W-1:0] event_bits_i,
  input  wire logic [rrts_pkg::ID_W-1:0]   target_task_i,
  // live task count and result hand-off
  input  wire logic [rrts_pkg::ID_W-1:0]   n_i,
  input  wire logic                        out_free_i,
  output      logic                        done_o,
  output      rrts_pkg::rsp_t              rsp_o,
  // timeout memory
  output      logic                        to_rd_en_o,
  output      logic [AW-1:0]               to_rd_addr_o,
  input  wire logic [rrts_pkg::DATA_W-1:0] to_rd_data_i,
  output      logic                        to_wr_en_o,
  output      logic [AW-1:0]               to_wr_addr_o,
  output      logic [rrts_pkg::DATA_W-1:0] to_wr_data_o,
  // wait mask memory
  output      logic                        mk_rd_en_o,
  output      logic [AW-1:0]               mk_rd_addr_o,
  input  wire logic [rrts_pkg::DATA_W-1:0] mk_rd_data_i,
  output      logic                        mk_wr_en_o,
  output      logic [AW-1:0]               mk_wr_addr_o,
  output      logic [rrts_pkg::DATA_W-1:0] mk_wr_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN,
    ST_RMW,
    ST_DONE
  } state_e;

  localparam logic [rrts_pkg::DATA_W-1:0] ONE = rrts_pkg::DATA_W'(1);

  state_e                        state_q, state_d;
  logic [rrts_pkg::ID_W-1:0]     cur_q, cur_d;
  logic [rrts_pkg::ID_W-1:0]     ptr_q, ptr_d;
  logic [rrts_pkg::ID_W-1:0]     cnt_q, cnt_d;
  rrts_pkg::req_e                type_q, type_d;
  logic [rrts_pkg::DATA_W-1:0]   amount_q, amount_d;
  logic [rrts_pkg::DATA_W-1:0]   bits_q, bits_d;
  logic                          none_q, none_d;
  logic                          exp_q, exp_d;
  logic                          stat_q, stat_d;

  logic [rrts_pkg::ID_W-1:0]     first_pos;
  logic [rrts_pkg::ID_W-1:0]     scan_nxt;
  logic [rrts_pkg::DATA_W-1:0]   tick_val;
  logic                          tgt_miss;
  logic                          runnable;
  rrts_pkg::req_e                req_type;

  // Round-robin successors: wrap after the last live task
  assign first_pos = (cur_q >= n_i) ? '0 : cur_q + 1'b1;
  assign scan_nxt  = (ptr_q >= n_i) ? '0 : ptr_q + 1'b1;
  assign tgt_miss  = target_task_i > n_i;
  assign req_type  = rrts_pkg::req_e'(req_type_i);

  // Tick update of one timeout; at or below the duration saturates to ready
  always_comb begin
    tick_val = to_rd_data_i;
    if (to_rd_data_i > ONE) begin
      tick_val = (to_rd_data_i <= amount_q) ? ONE : to_rd_data_i - amount_q;
    end
  end

  assign runnable = (to_rd_data_i <= ONE) && (mk_rd_data_i == '0);

  // Sequencer next state and memory commands
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    type_d       = type_q;
    amount_d     = amount_q;
    bits_d       = bits_q;
    none_d       = none_q;
    exp_d        = exp_q;
    stat_d       = stat_q;
    to_rd_en_o   = 1'b0;
    to_rd_addr_o = '0;
    to_wr_en_o   = 1'b0;
    to_wr_addr_o = '0;
    to_wr_data_o = '0;
    mk_rd_en_o   = 1'b0;
    mk_rd_addr_o = '0;
    mk_wr_en_o   = 1'b0;
    mk_wr_addr_o = '0;
    mk_wr_data_o = '0;
    done_o       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          type_d   = req_type;
          amount_d = amount_i;
          bits_d   = event_bits_i;
          none_d   = 1'b0;
          exp_d    = 1'b0;
          stat_d   = 1'b0;
          state_d  = ST_DONE;
          case (req_type)
            rrts_pkg::REQ_TICK: begin
              // idle task is not ticked; start at task 1
              if (n_i != '0) begin
                to_rd_en_o   = 1'b1;
                to_rd_addr_o = AW'(1);
                ptr_d        = rrts_pkg::ID_W'(1);
                state_d      = ST_TICK;
              end
            end
            rrts_pkg::REQ_YIELD: begin
              to_rd_en_o   = 1'b1;
              to_rd_addr_o = AW'(first_pos);
              mk_rd_en_o   = 1'b1;
              mk_rd_addr_o = AW'(first_pos);
              ptr_d        = first_pos;
              cnt_d        = '0;
              state_d      = ST_SCAN;
            end
            rrts_pkg::REQ_DELAY: begin
              to_wr_en_o   = 1'b1;
              to_wr_addr_o = AW'(cur_q);
              to_wr_data_o = amount_i;
            end
            rrts_pkg::REQ_WAIT: begin
              mk_rd_en_o   = 1'b1;
              mk_rd_addr_o = AW'(cur_q);
              ptr_d        = cur_q;
              state_d      = ST_RMW;
            end
            rrts_pkg::REQ_FEED: begin
              if (tgt_miss) begin
                stat_d = 1'b1;
              end else begin
                mk_rd_en_o   = 1'b1;
                mk_rd_addr_o = AW'(target_task_i);
                ptr_d        = target_task_i;
                state_d      = ST_RMW;
              end
            end
            rrts_pkg::REQ_CANCEL: begin
              if (tgt_miss) begin
                stat_d = 1'b1;
              end else begin
                to_wr_en_o   = 1'b1;
                to_wr_addr_o = AW'(target_task_i);
                to_wr_data_o = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_TICK: begin
        // write back entry ptr, prefetch the next one
        to_wr_en_o   = 1'b1;
        to_wr_addr_o = AW'(ptr_q);
        to_wr_data_o = tick_val;
        if (ptr_q < n_i) begin
          to_rd_en_o   = 1'b1;
          to_rd_addr_o = AW'(ptr_q + 1'b1);
          ptr_d        = ptr_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_SCAN: begin
        if (runnable) begin
          cur_d   = ptr_q;
          state_d = ST_DONE;
          if (to_rd_data_i == ONE) begin
            exp_d        = 1'b1;
            to_wr_en_o   = 1'b1;
            to_wr_addr_o = AW'(ptr_q);
            to_wr_data_o = '0;
          end
        end else if (cnt_q == n_i) begin
          // every task visited, running task itself last
          none_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          cnt_d        = cnt_q + 1'b1;
          to_rd_en_o   = 1'b1;
          to_rd_addr_o = AW'(scan_nxt);
          mk_rd_en_o   = 1'b1;
          mk_rd_addr_o = AW'(scan_nxt);
          ptr_d        = scan_nxt;
        end
      end

      ST_RMW: begin
        mk_wr_en_o   = 1'b1;
        mk_wr_addr_o = AW'(ptr_q);
        mk_wr_data_o = (type_q == rrts_pkg::REQ_WAIT) ? (mk_rd_data_i | bits_q)
                                                      : (mk_rd_data_i & ~bits_q);
        state_d      = ST_DONE;
      end

      ST_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cur_q    <= '0;
      ptr_q    <= '0;
      cnt_q    <= '0;
      type_q   <= rrts_pkg::REQ_TICK;
      amount_q <= '0;
      bits_q   <= '0;
      none_q   <= 1'b0;
      exp_q    <= 1'b0;
      stat_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      ptr_q    <= ptr_d;
      cnt_q    <= cnt_d;
      type_q   <= type_d;
      amount_q <= amount_d;
      bits_q   <= bits_d;
      none_q   <= none_d;
      exp_q    <= exp_d;
      stat_q   <= stat_d;
    end
  end

  assign req_ready_o         = (state_q == ST_IDLE);
  assign rsp_o.running_task  = cur_q;
  assign rsp_o.none_runnable = none_q;
  assign rsp_o.delay_expired = exp_q;
  assign rsp_o.status        = stat_q;

endmodule

`default_nettype wire
